### hw/rtl/kpdec_pkg.sv
// Shared constants, types and helper functions for the keypoint row decoder.
`timescale 1ns / 1ps

package kpdec_pkg;

   // Default sizes of the row layout
   localparam int COLOR_COUNT_DEF = 4;
   localparam int CLASS_COUNT_DEF = 9;
   localparam int VALUE_BITS_DEF  = 32;

   // Fixed row layout: eight corner coordinates, then the logit
   localparam int CORNER_VALUES = 8;
   localparam int CORNER_COUNT  = 4;
   localparam int LOGIT_COL     = 8;

   // Field and datapath widths
   localparam int VALUE_W     = 32;
   localparam int PAD_W       = 12;
   localparam int SCALE_W     = 24;
   localparam int FRAC_W      = 16;
   localparam int DIFF_W      = 34;
   localparam int PROD_W      = DIFF_W + SCALE_W + 1;
   localparam int BOX_W       = 16;
   localparam int COLOR_IDX_W = 2;
   localparam int CLASS_IDX_W = 4;
   localparam int CORNER_W    = 3;
   localparam int SEL_W       = 2;
   localparam int CSR_IDX_W   = 2;

   localparam int RSP_FIELD_W = 4 * VALUE_W + 4 * BOX_W + COLOR_IDX_W + CLASS_IDX_W - VALUE_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;
   localparam int REQ_DATA_W  = VALUE_W;

   // Register reset values
   localparam logic signed [VALUE_W-1:0] THRESHOLD_RST = -32'sd55530;
   localparam logic [PAD_W-1:0]          PAD_RST       = '0;
   localparam logic [SCALE_W-1:0]        INV_SCALE_RST = 24'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 2'd0,
      CSR_PAD_LEFT  = 2'd1,
      CSR_PAD_TOP   = 2'd2,
      CSR_INV_SCALE = 2'd3
   } csr_index_type;

   // Sideband that travels with a coordinate through the mapping pipeline
   typedef struct packed {
      logic                valid;
      logic [CORNER_W-1:0] slot;
   } coord_tag_type;

   // Q16.16 to integer, truncated toward zero
   function automatic logic [BOX_W-1:0] trunc_q16(input logic signed [VALUE_W-1:0] v);
      logic [BOX_W-1:0] q;
      q = v[VALUE_W-1:FRAC_W];
      if (v[VALUE_W-1] && (v[FRAC_W-1:0] != '0)) begin
         q = q + BOX_W'(1);
      end
      return q;
   endfunction

   // Integer span between two Q16.16 values, saturated at the box width
   function automatic logic [BOX_W-1:0] span_q16(input logic signed [VALUE_W-1:0] lo,
                                                 input logic signed [VALUE_W-1:0] hi);
      logic [VALUE_W:0] diff;
      diff = (VALUE_W + 1)'(hi) - (VALUE_W + 1)'(lo);
      if (diff[VALUE_W]) begin
         return '1;
      end
      return diff[VALUE_W-1:FRAC_W];
   endfunction

endpackage

### hw/rtl/keypoint_detection_row_decoder.sv
// Keypoint detection row decoder: top level with row bookkeeping and result buffer.
`timescale 1ns / 1ps

// Accepts one Q16.16 row value per clock on the request stream; a row is
// COLOR_COUNT + CLASS_COUNT + 9 values, last value marked by req_tlast. Each
// corner coordinate is mapped back to source pixels as it arrives, through a
// three-stage subtract / multiply / round pipeline, and the bounding box and
// score maxima are kept up to date on the fly, so a full row that passes the
// logit threshold yields its four corner results (p1, p4, p3, p2) from a
// result buffer in the cycle after its last value. Requests stream at one per
// cycle; the last column of a row stalls while the previous row's four results
// are still waiting to be taken, and, only with one colour and one class score,
// while the last corner leaves the mapping pipeline. Rows of the wrong length
// give nothing.
module keypoint_detection_row_decoder #(
   parameter int COLOR_COUNT = kpdec_pkg::COLOR_COUNT_DEF,
   parameter int CLASS_COUNT = kpdec_pkg::CLASS_COUNT_DEF,
   parameter int VALUE_BITS  = kpdec_pkg::VALUE_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // request stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [kpdec_pkg::REQ_DATA_W-1:0]      req_tdata,  // [31:0] element_value
   input  logic                                  req_tlast,  // row_end
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // [31:0] corner_x, [63:32] corner_y, [79:64] box_left, [95:80] box_top,
   // [111:96] box_width, [127:112] box_height, [129:128] color_index,
   // [133:130] class_index, [165:134] score_logit, [167:166] zero
   output logic [kpdec_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                  rsp_tlast,  // last_corner
   // register write port
   input  logic                                  csr_wr_en,
   input  logic [kpdec_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [kpdec_pkg::VALUE_W-1:0]         csr_wdata
);

   localparam int VAL_W        = kpdec_pkg::VALUE_W;
   localparam int BOX_W        = kpdec_pkg::BOX_W;
   localparam int COLOR_FIRST  = kpdec_pkg::LOGIT_COL + 1;
   localparam int CLASS_FIRST  = COLOR_FIRST + COLOR_COUNT;
   localparam int ROW_LEN      = CLASS_FIRST + CLASS_COUNT;
   localparam int CNT_W        = $clog2(ROW_LEN + 1);
   localparam int COLOR_SLOT_W = (COLOR_COUNT > 1) ? $clog2(COLOR_COUNT) : 1;
   localparam int CLASS_SLOT_W = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
   localparam int NCORN        = kpdec_pkg::CORNER_COUNT;
   localparam int SEL_W        = kpdec_pkg::SEL_W;

   // Configuration registers
   logic signed [VAL_W-1:0]              thr_ff;
   logic [kpdec_pkg::PAD_W-1:0]          pad_left_ff, pad_top_ff;
   logic [kpdec_pkg::SCALE_W-1:0]        inv_scale_ff;

   // Row state
   logic [CNT_W-1:0]                     count_ff, count_in;
   logic signed [VAL_W-1:0]              logit_ff;
   logic signed [VAL_W-1:0]              best_color_ff, best_color_in;
   logic [COLOR_SLOT_W-1:0]              color_slot_ff, color_slot_in;
   logic signed [VAL_W-1:0]              best_class_ff, best_class_in;
   logic [CLASS_SLOT_W-1:0]              class_slot_ff, class_slot_in;

   // Mapped corners and running box
   logic signed [VAL_W-1:0]              corner_x_ff [NCORN];
   logic signed [VAL_W-1:0]              corner_y_ff [NCORN];
   logic signed [VAL_W-1:0]              min_x_ff, max_x_ff, min_y_ff, max_y_ff;

   // Result buffer
   logic signed [VAL_W-1:0]              snap_x_ff [NCORN];
   logic signed [VAL_W-1:0]              snap_y_ff [NCORN];
   logic [BOX_W-1:0]                     snap_left_ff, snap_top_ff;
   logic [BOX_W-1:0]                     snap_width_ff, snap_height_ff;
   logic [kpdec_pkg::COLOR_IDX_W-1:0]    snap_color_ff;
   logic [kpdec_pkg::CLASS_IDX_W-1:0]    snap_class_ff;
   logic signed [VAL_W-1:0]              snap_logit_ff;
   logic                                 busy_ff, busy_in;
   logic [SEL_W-1:0]                     sel_ff, sel_in;

   logic                                 req_fire, rsp_fire, load;
   logic signed [VAL_W-1:0]              value;
   kpdec_pkg::coord_tag_type             map_in_tag, map_out_tag;
   logic signed [VAL_W-1:0]              map_out_value;
   logic [SEL_W-1:0]                     map_k;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign value    = VAL_W'($signed(req_tdata[VALUE_BITS-1:0]));

   // Hold the last column while the buffer still owes results or a corner is
   // still on its way out of the mapping pipeline
   assign req_tready = !((busy_ff || map_out_tag.valid)
                         && (count_ff == CNT_W'(ROW_LEN - 1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff       <= kpdec_pkg::THRESHOLD_RST;
         pad_left_ff  <= kpdec_pkg::PAD_RST;
         pad_top_ff   <= kpdec_pkg::PAD_RST;
         inv_scale_ff <= kpdec_pkg::INV_SCALE_RST;
      end else if (csr_wr_en) begin
         case (kpdec_pkg::csr_index_type'(csr_index))
            kpdec_pkg::CSR_THRESHOLD: begin
               thr_ff <= $signed(csr_wdata);
            end
            kpdec_pkg::CSR_PAD_LEFT: begin
               pad_left_ff <= csr_wdata[kpdec_pkg::PAD_W-1:0];
            end
            kpdec_pkg::CSR_PAD_TOP: begin
               pad_top_ff <= csr_wdata[kpdec_pkg::PAD_W-1:0];
            end
            kpdec_pkg::CSR_INV_SCALE: begin
               inv_scale_ff <= csr_wdata[kpdec_pkg::SCALE_W-1:0];
            end
            default: begin
               thr_ff <= thr_ff;
            end
         endcase
      end
   end

   // Corners go to the mapping pipeline as they arrive
   assign map_in_tag.valid = req_fire && (count_ff < CNT_W'(kpdec_pkg::CORNER_VALUES));
   assign map_in_tag.slot  = count_ff[kpdec_pkg::CORNER_W-1:0];

   kpdec_coord_map u_coord_map (
      .clock     (clock),
      .reset     (reset),
      .in_tag    (map_in_tag),
      .in_value  (value),
      .in_pad    (count_ff[0] ? pad_top_ff : pad_left_ff),
      .inv_scale (inv_scale_ff),
      .out_tag   (map_out_tag),
      .out_value (map_out_value)
   );

   assign map_k = map_out_tag.slot[kpdec_pkg::CORNER_W-1:1];

   always_ff @(posedge clock) begin
      if (map_out_tag.valid) begin
         if (!map_out_tag.slot[0]) begin
            corner_x_ff[map_k] <= map_out_value;
            if (map_k == '0 || map_out_value < min_x_ff) begin
               min_x_ff <= map_out_value;
            end
            if (map_k == '0 || map_out_value > max_x_ff) begin
               max_x_ff <= map_out_value;
            end
         end else begin
            corner_y_ff[map_k] <= map_out_value;
            if (map_k == '0 || map_out_value < min_y_ff) begin
               min_y_ff <= map_out_value;
            end
            if (map_k == '0 || map_out_value > max_y_ff) begin
               max_y_ff <= map_out_value;
            end
         end
      end
   end

   // Column bookkeeping and running argmax, including the value now arriving
   always_comb begin
      best_color_in = best_color_ff;
      color_slot_in = color_slot_ff;
      best_class_in = best_class_ff;
      class_slot_in = class_slot_ff;
      count_in      = count_ff;
      load          = 1'b0;
      if (req_fire) begin
         if (count_ff >= CNT_W'(COLOR_FIRST) && count_ff < CNT_W'(CLASS_FIRST)) begin
            if (count_ff == CNT_W'(COLOR_FIRST) || value > best_color_ff) begin
               best_color_in = value;
               color_slot_in = COLOR_SLOT_W'(count_ff - CNT_W'(COLOR_FIRST));
            end
         end
         if (count_ff >= CNT_W'(CLASS_FIRST) && count_ff < CNT_W'(ROW_LEN)) begin
            if (count_ff == CNT_W'(CLASS_FIRST) || value > best_class_ff) begin
               best_class_in = value;
               class_slot_in = CLASS_SLOT_W'(count_ff - CNT_W'(CLASS_FIRST));
            end
         end
         if (!req_tlast) begin
            if (count_ff < CNT_W'(ROW_LEN)) begin
               count_in = count_ff + CNT_W'(1);
            end
         end else begin
            count_in = '0;
            load     = (count_ff == CNT_W'(ROW_LEN - 1)) && !(logit_ff < thr_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         color_slot_ff <= '0;
         class_slot_ff <= '0;
      end else begin
         count_ff      <= count_in;
         color_slot_ff <= color_slot_in;
         class_slot_ff <= class_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      best_color_ff <= best_color_in;
      best_class_ff <= best_class_in;
      if (req_fire && count_ff == CNT_W'(kpdec_pkg::LOGIT_COL)) begin
         logit_ff <= value;
      end
   end

   // Result buffer: four results per accepted row
   always_comb begin
      busy_in = busy_ff;
      sel_in  = sel_ff;
      if (load) begin
         busy_in = 1'b1;
         sel_in  = '0;
      end else if (rsp_fire) begin
         sel_in = sel_ff + SEL_W'(1);
         if (sel_ff == SEL_W'(NCORN - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         sel_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         sel_ff  <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         // Emit order p1, p4, p3, p2
         snap_x_ff[0]   <= corner_x_ff[0];
         snap_y_ff[0]   <= corner_y_ff[0];
         snap_x_ff[1]   <= corner_x_ff[3];
         snap_y_ff[1]   <= corner_y_ff[3];
         snap_x_ff[2]   <= corner_x_ff[2];
         snap_y_ff[2]   <= corner_y_ff[2];
         snap_x_ff[3]   <= corner_x_ff[1];
         snap_y_ff[3]   <= corner_y_ff[1];
         snap_left_ff   <= kpdec_pkg::trunc_q16(min_x_ff);
         snap_top_ff    <= kpdec_pkg::trunc_q16(min_y_ff);
         snap_width_ff  <= kpdec_pkg::span_q16(min_x_ff, max_x_ff);
         snap_height_ff <= kpdec_pkg::span_q16(min_y_ff, max_y_ff);
         snap_color_ff  <= kpdec_pkg::COLOR_IDX_W'(color_slot_in);
         snap_class_ff  <= kpdec_pkg::CLASS_IDX_W'(class_slot_in);
         snap_logit_ff  <= logit_ff;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = (sel_ff == SEL_W'(NCORN - 1));
   assign rsp_tdata  = {{(kpdec_pkg::RSP_DATA_W - kpdec_pkg::RSP_FIELD_W){1'b0}},
                        snap_logit_ff, snap_class_ff, snap_color_ff,
                        snap_height_ff, snap_width_ff, snap_top_ff, snap_left_ff,
                        snap_y_ff[sel_ff], snap_x_ff[sel_ff]};

endmodule

### hw/rtl/kpdec_coord_map.sv
// Letterbox undo pipeline: pad subtract, inverse scale multiply, round and saturate.
`timescale 1ns / 1ps

module kpdec_coord_map (
   input  logic                                       clock,
   input  logic                                       reset,
   input  kpdec_pkg::coord_tag_type                   in_tag,
   input  logic signed [kpdec_pkg::VALUE_W-1:0]       in_value,
   input  logic        [kpdec_pkg::PAD_W-1:0]         in_pad,
   input  logic        [kpdec_pkg::SCALE_W-1:0]       inv_scale,
   output kpdec_pkg::coord_tag_type                   out_tag,
   output logic signed [kpdec_pkg::VALUE_W-1:0]       out_value
);

   localparam int DIFF_W = kpdec_pkg::DIFF_W;
   localparam int PROD_W = kpdec_pkg::PROD_W;
   localparam int FRAC_W = kpdec_pkg::FRAC_W;
   localparam int VAL_W  = kpdec_pkg::VALUE_W;
   localparam int SH_W   = PROD_W - FRAC_W;

   kpdec_pkg::coord_tag_type   tag_d_ff, tag_p_ff, tag_o_ff;
   logic signed [DIFF_W-1:0]   diff_in, diff_ff;
   logic signed [PROD_W-1:0]   prod_in, prod_ff;
   logic signed [PROD_W-1:0]   rounded;
   logic signed [SH_W-1:0]     shifted;
   logic signed [VAL_W-1:0]    value_in, value_ff;

   // Pad sits in whole pixels, so it lines up with the integer part
   assign diff_in = DIFF_W'(in_value)
                  - $signed({{(DIFF_W - kpdec_pkg::PAD_W - FRAC_W){1'b0}}, in_pad,
                             {FRAC_W{1'b0}}});

   assign prod_in = PROD_W'(diff_ff) * PROD_W'($signed({1'b0, inv_scale}));

   // Round half up, then drop the extra fraction bits
   assign rounded = prod_ff + PROD_W'(32768);
   assign shifted = $signed(rounded[PROD_W-1:FRAC_W]);

   always_comb begin
      if (shifted[SH_W-1:VAL_W-1] == '0 || shifted[SH_W-1:VAL_W-1] == '1) begin
         value_in = shifted[VAL_W-1:0];
      end else if (shifted[SH_W-1]) begin
         value_in = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         value_in = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_d_ff <= '0;
         tag_p_ff <= '0;
         tag_o_ff <= '0;
      end else begin
         tag_d_ff <= in_tag;
         tag_p_ff <= tag_d_ff;
         tag_o_ff <= tag_p_ff;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff  <= diff_in;
      prod_ff  <= prod_in;
      value_ff <= value_in;
   end

   assign out_tag   = tag_o_ff;
   assign out_value = value_ff;

endmodule

### dv/kpdec_row_checker.sv
// Scoreboard for the keypoint row decoder: mirrors registers, predicts corner results, compares.
`timescale 1ns / 1ps

module kpdec_row_checker
   import kpdec_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] element_value
   input  logic                  req_tlast,   // row_end
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,   // corner_x .. score_logit, see the block's port list
   input  logic                  rsp_tlast,   // last_corner
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [VALUE_W-1:0]    csr_wdata,
   output int                    fail_count,
   output int                    pending_corners
);

   localparam int COLOR_FIRST = LOGIT_COL + 1;
   localparam int CLASS_FIRST = COLOR_FIRST + COLOR_COUNT_DEF;
   localparam int ROW_LEN     = CLASS_FIRST + CLASS_COUNT_DEF;
   localparam longint Q_MAX   = 64'sd2147483647;
   localparam longint Q_MIN   = -64'sd2147483648;

   typedef struct {
      logic signed [VALUE_W-1:0] corner_x;
      logic signed [VALUE_W-1:0] corner_y;
      logic signed [BOX_W-1:0]   box_left;
      logic signed [BOX_W-1:0]   box_top;
      logic [BOX_W-1:0]          box_width;
      logic [BOX_W-1:0]          box_height;
      logic [COLOR_IDX_W-1:0]    color_index;
      logic [CLASS_IDX_W-1:0]    class_index;
      logic signed [VALUE_W-1:0] score_logit;
      logic                      last_corner;
   } corner_result_type;

   corner_result_type corner_queue[$];

   // register mirror
   logic signed [VALUE_W-1:0] logit_floor;
   logic [PAD_W-1:0]          pad_x;
   logic [PAD_W-1:0]          pad_y;
   logic [SCALE_W-1:0]        inv_scale;

   // row being collected
   int     col_pos;
   longint coord_store[CORNER_VALUES];
   longint held_logit;
   longint top_color_score;
   longint top_class_score;
   int     top_color_idx;
   int     top_class_idx;

   // Q16.16 model pixels to source pixels, rounding halves upward, saturated
   function automatic longint map_to_source(input longint v, input longint pad,
                                            input longint scale);
      longint scaled;
      longint r;
      scaled = (v - pad * 65536) * scale;
      r = (scaled + 32768) >>> 16;
      if (r > Q_MAX) r = Q_MAX;
      if (r < Q_MIN) r = Q_MIN;
      return r;
   endfunction

   task automatic take_element(input logic [VALUE_W-1:0] data, input logic row_end);
      longint v;
      longint xs[CORNER_COUNT];
      longint ys[CORNER_COUNT];
      longint minx, maxx, miny, maxy, w, h;
      int c;
      int q;
      corner_result_type item;
      v = longint'(signed'(data));
      c = col_pos;
      if (c < CORNER_VALUES) begin
         coord_store[c] = v;
      end else if (c == LOGIT_COL) begin
         held_logit = v;
      end else if (c < CLASS_FIRST) begin
         if (c == COLOR_FIRST || v > top_color_score) begin
            top_color_score = v;
            top_color_idx   = c - COLOR_FIRST;
         end
      end else if (c < ROW_LEN) begin
         if (c == CLASS_FIRST || v > top_class_score) begin
            top_class_score = v;
            top_class_idx   = c - CLASS_FIRST;
         end
      end
      if (!row_end) begin
         // hold at the row length on an overlong row
         if (c < ROW_LEN) col_pos = c + 1;
         return;
      end
      col_pos = 0;
      if (c != ROW_LEN - 1 || held_logit < longint'(logit_floor)) return;

      for (int k = 0; k < CORNER_COUNT; k++) begin
         xs[k] = map_to_source(coord_store[2*k], longint'(pad_x), longint'(inv_scale));
         ys[k] = map_to_source(coord_store[2*k+1], longint'(pad_y), longint'(inv_scale));
      end
      minx = xs[0];
      maxx = xs[0];
      miny = ys[0];
      maxy = ys[0];
      for (int k = 1; k < CORNER_COUNT; k++) begin
         if (xs[k] < minx) minx = xs[k];
         if (xs[k] > maxx) maxx = xs[k];
         if (ys[k] < miny) miny = ys[k];
         if (ys[k] > maxy) maxy = ys[k];
      end
      w = (maxx - minx) / 65536;
      h = (maxy - miny) / 65536;
      if (w > 65535) w = 65535;
      if (h > 65535) h = 65535;

      // corners leave in the order p1, p4, p3, p2
      for (int k = 0; k < CORNER_COUNT; k++) begin
         q = (CORNER_COUNT - k) % CORNER_COUNT;
         item.corner_x    = 32'(xs[q]);
         item.corner_y    = 32'(ys[q]);
         item.box_left    = 16'(minx / 65536);
         item.box_top     = 16'(miny / 65536);
         item.box_width   = 16'(w);
         item.box_height  = 16'(h);
         item.color_index = COLOR_IDX_W'(top_color_idx);
         item.class_index = CLASS_IDX_W'(top_class_idx);
         item.score_logit = 32'(held_logit);
         item.last_corner = (k == CORNER_COUNT - 1);
         corner_queue = {corner_queue, item};
      end
   endtask

   function automatic void compare_field(input string name, input longint want,
                                         input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   task automatic check_corner();
      corner_result_type want;
      if (corner_queue.size() == 0) begin
         fail_count++;
         $display("%0t: corner result with none expected, expected nothing, got %h / %b",
                  $time, rsp_tdata, rsp_tlast);
         return;
      end
      want = corner_queue.pop_front();
      compare_field("corner_x", longint'(want.corner_x), longint'(signed'(rsp_tdata[31:0])));
      compare_field("corner_y", longint'(want.corner_y), longint'(signed'(rsp_tdata[63:32])));
      compare_field("box_left", longint'(want.box_left), longint'(signed'(rsp_tdata[79:64])));
      compare_field("box_top", longint'(want.box_top), longint'(signed'(rsp_tdata[95:80])));
      compare_field("box_width", longint'(want.box_width), longint'(rsp_tdata[111:96]));
      compare_field("box_height", longint'(want.box_height), longint'(rsp_tdata[127:112]));
      compare_field("color_index", longint'(want.color_index), longint'(rsp_tdata[129:128]));
      compare_field("class_index", longint'(want.class_index), longint'(rsp_tdata[133:130]));
      compare_field("score_logit", longint'(want.score_logit),
                    longint'(signed'(rsp_tdata[165:134])));
      compare_field("last_corner", longint'(want.last_corner), longint'(rsp_tlast));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         logit_floor     = THRESHOLD_RST;
         pad_x           = PAD_RST;
         pad_y           = PAD_RST;
         inv_scale       = INV_SCALE_RST;
         col_pos         = 0;
         held_logit      = 0;
         top_color_score = 0;
         top_class_score = 0;
         top_color_idx   = 0;
         top_class_idx   = 0;
         for (int i = 0; i < CORNER_VALUES; i++) coord_store[i] = 0;
         corner_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD: logit_floor = signed'(csr_wdata);
               CSR_PAD_LEFT:  pad_x       = csr_wdata[PAD_W-1:0];
               CSR_PAD_TOP:   pad_y       = csr_wdata[PAD_W-1:0];
               CSR_INV_SCALE: inv_scale   = csr_wdata[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) take_element(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) check_corner();
      end
      pending_corners = corner_queue.size();
   end

endmodule

### dv/tb_keypoint_detection_row_decoder.sv
// Testbench top for the keypoint row decoder: clock, reset, row stimulus and verdict.
`timescale 1ns / 1ps

module tb_keypoint_detection_row_decoder;
   import kpdec_pkg::*;

   localparam int ROW_LEN       = LOGIT_COL + 1 + COLOR_COUNT_DEF + CLASS_COUNT_DEF;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 400;
   localparam int CYCLE_LIMIT   = 200000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [31:0] element_value
   logic                  req_tlast;   // row_end
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // corner_x, corner_y, box, indexes, score_logit
   logic                  rsp_tlast;   // last_corner
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [VALUE_W-1:0]    csr_wdata;

   int fail_count;
   int pending_corners;
   int cycle_count = 0;

   bit quiet        = 0;
   bit sender_gaps  = 0;
   bit hold_pending = 0;

   // what the stimulus currently believes the registers hold
   logic signed [VALUE_W-1:0] cur_floor;
   logic [PAD_W-1:0]          cur_pad_x;
   logic [PAD_W-1:0]          cur_pad_y;

   keypoint_detection_row_decoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   kpdec_row_checker row_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tlast       (req_tlast),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .pending_corners (pending_corners)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // result side: random ready bursts, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 0;
            rsp_tready   = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else if (quiet || $urandom_range(0, 2) != 0) begin
            rsp_tready = 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end else begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
   end

   // offer one request and hold it until taken; starts and ends at a falling edge
   task automatic push_value(input logic [VALUE_W-1:0] value, input logic row_end);
      if (sender_gaps && !quiet && $urandom_range(0, 4) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = value;
      req_tlast  = row_end;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [VALUE_W-1:0] value);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      case (idx)
         CSR_THRESHOLD: cur_floor = signed'(value);
         CSR_PAD_LEFT:  cur_pad_x = value[PAD_W-1:0];
         CSR_PAD_TOP:   cur_pad_y = value[PAD_W-1:0];
         default: ;
      endcase
   endtask

   // pad registers get junk in the unused upper bits
   task automatic set_config(input logic [VALUE_W-1:0] floor_val, input logic [PAD_W-1:0] px,
                             input logic [PAD_W-1:0] py, input logic [VALUE_W-1:0] scale);
      write_reg(CSR_THRESHOLD, floor_val);
      write_reg(CSR_PAD_LEFT, {20'($urandom), px});
      write_reg(CSR_PAD_TOP, {20'($urandom), py});
      write_reg(CSR_INV_SCALE, scale);
   endtask

   // drop valid, wait for every corner to come back, then let dropped rows finish
   task automatic settle();
      req_tvalid = 1'b0;
      req_tlast  = 1'b0;
      while (pending_corners != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [VALUE_W-1:0] pick_coord(input logic [PAD_W-1:0] pad);
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return $urandom;
         3:       return 32'($urandom_range(0, 65535));
         default: return ((32'(pad) + 32'($urandom_range(0, 900))) << 16)
                         | 32'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_logit();
      case ($urandom_range(0, 5))
         0:       return cur_floor;
         1:       return cur_floor - 1;
         5:       return $urandom;
         default: return cur_floor + 32'($urandom_range(0, 5000000));
      endcase
   endfunction

   // narrow values make ties between scores likely
   function automatic logic [VALUE_W-1:0] pick_score();
      case ($urandom_range(0, 4))
         2:       return 32'($urandom_range(0, 3)) - 32'd2;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_row(input int length, input bit force_pass);
      logic [VALUE_W-1:0] value;
      for (int col = 0; col < length; col++) begin
         if (col < CORNER_VALUES) value = pick_coord(col % 2 ? cur_pad_y : cur_pad_x);
         else if (col == LOGIT_COL) value = force_pass ? 32'h7FFF_FFFF : pick_logit();
         else value = pick_score();
         push_value(value, col == length - 1);
      end
   endtask

   task automatic send_random_rows(input int count);
      int kind;
      for (int r = 0; r < count; r++) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) send_row($urandom_range(1, ROW_LEN - 1), 1'b0);
         else if (kind == 1) send_row($urandom_range(ROW_LEN + 1, ROW_LEN + 5), 1'b0);
         else send_row(ROW_LEN, 1'b0);
      end
   endtask

   initial begin
      logic [VALUE_W-1:0] edge_row[ROW_LEN];
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_THRESHOLD;
      csr_wdata  = '0;
      cur_floor  = THRESHOLD_RST;
      cur_pad_x  = PAD_RST;
      cur_pad_y  = PAD_RST;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      // full-scale corners, logit exactly at the floor, tied colours, tied top classes
      edge_row = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
                   THRESHOLD_RST,
                   32'd5, 32'd5, 32'd5, 32'd5,
                   32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                   32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000};
      for (int i = 0; i < ROW_LEN; i++) push_value(edge_row[i], i == ROW_LEN - 1);
      // row ended early: discard
      push_value(32'h0001_0000, 1'b0);
      push_value(32'h0002_0000, 1'b0);
      push_value(32'h0003_0000, 1'b1);
      settle();

      for (int ph = 0; ph < 6; ph++) begin
         sender_gaps = $urandom_range(0, 1);
         case (ph)
            0: begin
               set_config(32'($urandom_range(0, 200000)) - 32'd100000,
                          12'($urandom_range(0, 200)), 12'($urandom_range(0, 200)),
                          32'($urandom_range(20000, 200000)));
               send_random_rows(1);
            end
            1: begin
               // lowest floor, largest scale: every full-length row passes
               set_config(32'h8000_0000, '0, '0, 32'h00FF_FFFF);
               send_random_rows(1);
            end
            2: begin
               // highest floor, largest pads, zero scale
               set_config(32'h7FFF_FFFF, 12'hFFF, 12'hFFF, 32'h0000_0000);
               send_random_rows(1);
            end
            3: begin
               set_config($urandom, 12'($urandom), 12'($urandom), $urandom);
               send_random_rows(1);
            end
            4: begin
               // stall the result side so the block fills and pushes back
               set_config(32'h8000_0000, 12'($urandom_range(0, 300)),
                          12'($urandom_range(0, 300)), 32'($urandom_range(1, 131072)));
               hold_pending = 1;
               for (int r = 0; r < 2; r++) send_row(ROW_LEN, 1'b1);
            end
            default: begin
               quiet = 1;
               set_config(32'($urandom_range(0, 100000)) - 32'd50000,
                          12'($urandom_range(0, 100)), 12'($urandom_range(0, 100)),
                          32'h0000_0001);
               send_random_rows(1);
            end
         endcase
         settle();
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
